// File: src/mmpd_pkg.sv
// Shared types and constants of the min/max peak decimator.
package mmpd_pkg;

  localparam int SPP_W           = 40;
  localparam int START_W         = 40;
  localparam int COUNT_W         = 13;
  localparam int COLUMN_W        = 12;
  localparam int FRAC_W          = 16;
  localparam int SPP_INT_W       = SPP_W - FRAC_W;
  localparam int IDX_W           = 42;
  localparam int STRIDE_W        = 18;
  localparam int REM_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 40;
  localparam int FIFO_DEPTH      = 2;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // A length below 2^24, shifted right by two, times RECIP_BY_100 and then shifted right by
  // RECIP_SHIFT gives the length divided by 100.
  localparam int RECIP_W         = 23;
  localparam int RECIP_SHIFT     = 27;
  localparam int PROD_W          = SPP_INT_W - 2 + RECIP_W;

  localparam logic [REM_W-1:0]   INSPECT_DIVISOR = REM_W'(100);
  localparam logic [SPP_W-1:0]   SPP_ONE         = SPP_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET     = COUNT_W'(4096);
  localparam logic [RECIP_W-1:0] RECIP_BY_100    = RECIP_W'(5368710);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPP   = 2'd0,
    REG_START = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FS_DIV,
    FS_INIT,
    FS_RUN
  } front_state_e;

  typedef struct packed {
    logic                inspect;
    logic                close;
    logic                last;
    logic [COLUMN_W-1:0] column;
  } mid_ctl_t;

endpackage

// File: src/mmpd_fifo.sv
// Small register queue with flush, used between the stages and at the output.
module mmpd_fifo
  import mmpd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             flush_i,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/mmpd_front.sv
// Front stage: configuration, sample indexing, column bounds and inspection stride.
module mmpd_front
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  mid_full_i,
  output logic                  mid_push_o,
  output mid_ctl_t              mid_ctl_o,
  output logic                  restart_o
);

  front_state_e state_q, state_d;

  logic [SPP_W-1:0]     spp_q, spp_d;
  logic [START_W-1:0]   start_q, start_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  logic [STRIDE_W-1:0]  quo_q, quo_d;

  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     last_idx_q, last_idx_d;
  logic [FRAC_W-1:0]    frac_q, frac_d;
  logic [COUNT_W-1:0]   col_q, col_d;
  logic [STRIDE_W-1:0]  cnt_q, cnt_d;
  logic [STRIDE_W-1:0]  cur_m1_q, cur_m1_d;
  logic [STRIDE_W-1:0]  s0_m1_q, s0_m1_d;
  logic [STRIDE_W-1:0]  s1_m1_q, s1_m1_d;
  logic                 finished_q, finished_d;

  logic [SPP_W-1:0]     eff_spp;
  logic [SPP_INT_W-1:0] len_int;
  logic [FRAC_W-1:0]    len_frac;
  logic [COUNT_W-1:0]   eff_count;
  logic [PROD_W-1:0]    quo_prod;
  logic [SPP_INT_W-1:0] quo_rem;
  logic [STRIDE_W-1:0]  quo_up;
  logic [FRAC_W:0]      frac_sum;
  logic                 accept, inspect, close, last_col, cfg_hit;

  assign eff_spp   = (spp_q < SPP_ONE) ? SPP_ONE : spp_q;
  assign len_int   = eff_spp[SPP_W-1:FRAC_W];
  assign len_frac  = eff_spp[FRAC_W-1:0];
  assign quo_prod  = PROD_W'(len_int[SPP_INT_W-1:2]) * PROD_W'(RECIP_BY_100);
  assign quo_rem   = len_int - SPP_INT_W'(quo_q) * SPP_INT_W'(INSPECT_DIVISOR);
  assign quo_up    = quo_q
                   + STRIDE_W'(quo_rem == SPP_INT_W'(INSPECT_DIVISOR - REM_W'(1)));
  assign frac_sum  = {1'b0, frac_q} + {1'b0, len_frac};

  always_comb begin
    if (count_q == '0) begin
      eff_count = COUNT_W'(1);
    end else if (32'(count_q) > MAX_COLUMNS) begin
      eff_count = COUNT_W'(MAX_COLUMNS);
    end else begin
      eff_count = count_q;
    end
  end

  assign full     = (state_q != FS_RUN) || mid_full_i;
  assign accept   = push && !full;
  assign inspect  = (cnt_q == '0);
  assign close    = (idx_q == last_idx_q);
  assign last_col = ((col_q + COUNT_W'(1)) == eff_count);

  always_comb begin
    state_d    = state_q;
    spp_d      = spp_q;
    start_d    = start_q;
    count_d    = count_q;
    quo_d      = quo_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    frac_d     = frac_q;
    col_d      = col_q;
    cnt_d      = cnt_q;
    cur_m1_d   = cur_m1_q;
    s0_m1_d    = s0_m1_q;
    s1_m1_d    = s1_m1_q;
    finished_d = finished_q;
    mid_push_o = 1'b0;
    mid_ctl_o  = '0;
    cfg_hit    = 1'b0;

    unique case (state_q)
      FS_DIV: begin
        quo_d   = STRIDE_W'(quo_prod >> RECIP_SHIFT);
        state_d = FS_INIT;
      end
      FS_INIT: begin
        s0_m1_d    = (quo_q == '0) ? '0 : quo_q - STRIDE_W'(1);
        s1_m1_d    = (quo_up == '0) ? '0 : quo_up - STRIDE_W'(1);
        cur_m1_d   = s0_m1_d;
        last_idx_d = IDX_W'(start_q) + IDX_W'(len_int) - IDX_W'(1);
        frac_d     = len_frac;
        idx_d      = '0;
        col_d      = '0;
        cnt_d      = '0;
        finished_d = 1'b0;
        state_d    = FS_RUN;
      end
      FS_RUN: begin
        if (accept && !finished_q) begin
          idx_d = idx_q + IDX_W'(1);
          if (idx_q >= IDX_W'(start_q)) begin
            cnt_d = inspect ? cur_m1_q : cnt_q - STRIDE_W'(1);
            if (inspect || close) begin
              mid_push_o        = 1'b1;
              mid_ctl_o.inspect = inspect;
              mid_ctl_o.close   = close;
              mid_ctl_o.last    = last_col;
              mid_ctl_o.column  = col_q[COLUMN_W-1:0];
            end
            if (close) begin
              if (last_col) begin
                finished_d = 1'b1;
              end else begin
                col_d      = col_q + COUNT_W'(1);
                frac_d     = frac_sum[FRAC_W-1:0];
                last_idx_d = last_idx_q + IDX_W'(len_int) + IDX_W'(frac_sum[FRAC_W]);
                cur_m1_d   = frac_sum[FRAC_W] ? s1_m1_q : s0_m1_q;
                cnt_d      = '0;
              end
            end
          end
        end
      end
      default: begin
        state_d = FS_DIV;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPP: begin
          spp_d   = SPP_W'(cfg_data_i);
          cfg_hit = 1'b1;
        end
        REG_START: begin
          start_d = START_W'(cfg_data_i);
          cfg_hit = 1'b1;
        end
        REG_COUNT: begin
          count_d = cfg_data_i[COUNT_W-1:0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    if (cfg_hit) begin
      state_d = FS_DIV;
    end
  end

  assign restart_o = cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_DIV;
      spp_q      <= SPP_ONE;
      start_q    <= '0;
      count_q    <= COUNT_RESET;
      quo_q      <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
      frac_q     <= '0;
      col_q      <= '0;
      cnt_q      <= '0;
      cur_m1_q   <= '0;
      s0_m1_q    <= '0;
      s1_m1_q    <= '0;
      finished_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      spp_q      <= spp_d;
      start_q    <= start_d;
      count_q    <= count_d;
      quo_q      <= quo_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      frac_q     <= frac_d;
      col_q      <= col_d;
      cnt_q      <= cnt_d;
      cur_m1_q   <= cur_m1_d;
      s0_m1_q    <= s0_m1_d;
      s1_m1_q    <= s1_m1_d;
      finished_q <= finished_d;
    end
  end

endmodule

// File: src/mmpd_back.sv
// Back stage: per-column minimum and maximum, running peak magnitude and result words.
module mmpd_back
  import mmpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          mid_empty_i,
  input  mid_ctl_t                      mid_ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] mid_sample_i,
  output logic                          mid_pop_o,
  input  logic                          out_full_i,
  output logic                          out_push_o,
  output logic [COLUMN_W-1:0]           column_o,
  output logic signed [SAMPLE_BITS-1:0] min_value_o,
  output logic signed [SAMPLE_BITS-1:0] max_value_o,
  output logic [SAMPLE_BITS-1:0]        peak_abs_o,
  output logic                          last_o
);

  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [SAMPLE_BITS-1:0]        peak_q, peak_d;
  logic                          has_q, has_d;
  logic                          take;
  logic [SAMPLE_BITS-1:0]        mag_min, mag_max, peak_n;

  assign mid_pop_o = !mid_empty_i && !out_full_i;
  assign take      = mid_pop_o && mid_ctl_i.inspect;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (take && (!has_q || (mid_sample_i < min_q))) begin
      min_d = mid_sample_i;
    end
    if (take && (!has_q || (mid_sample_i > max_q))) begin
      max_d = mid_sample_i;
    end
  end

  assign mag_min = min_d[SAMPLE_BITS-1] ? (~min_d + SAMPLE_BITS'(1)) : min_d;
  assign mag_max = max_d[SAMPLE_BITS-1] ? (~max_d + SAMPLE_BITS'(1)) : max_d;

  always_comb begin
    peak_n = peak_q;
    if (mag_min > peak_n) begin
      peak_n = mag_min;
    end
    if (mag_max > peak_n) begin
      peak_n = mag_max;
    end
  end

  assign out_push_o  = mid_pop_o && mid_ctl_i.close;
  assign column_o    = mid_ctl_i.column;
  assign min_value_o = min_d;
  assign max_value_o = max_d;
  assign peak_abs_o  = peak_n;
  assign last_o      = mid_ctl_i.last;

  always_comb begin
    has_d  = has_q;
    peak_d = peak_q;
    if (restart_i) begin
      has_d  = 1'b0;
      peak_d = '0;
    end else if (mid_pop_o) begin
      if (mid_ctl_i.close) begin
        has_d  = 1'b0;
        peak_d = peak_n;
      end else begin
        has_d = has_q || mid_ctl_i.inspect;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q  <= 1'b0;
      peak_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else begin
      has_q  <= has_d;
      peak_q <= peak_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

endmodule

// File: src/minmax_peak_decimator.sv
// Top level of the min/max peak decimator for waveform display.
// Samples are taken one per clock cycle whenever the middle queue has room; each
// column's result word leaves through a two-entry output queue, so a stalled
// consumer only backs up the block once both the output and middle queues fill.
// After reset and after every write to the SPP, START or COUNT register the
// block holds full high while the integer column length is divided by 100
// through a reciprocal multiplication (FS_DIV) and then set up (FS_INIT), before
// it takes samples again. A column's result word goes through the middle queue and
// the back stage into the output queue; it is on the result ports at that queue's head.
module minmax_peak_decimator
  import mmpd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [COLUMN_W-1:0]           column_o,
  output logic signed [SAMPLE_BITS-1:0] min_value_o,
  output logic signed [SAMPLE_BITS-1:0] max_value_o,
  output logic [SAMPLE_BITS-1:0]        peak_abs_o,
  output logic                          last_o
);

  localparam int MID_W = $bits(mid_ctl_t) + SAMPLE_BITS;
  localparam int OUT_W = COLUMN_W + 3 * SAMPLE_BITS + 1;

  logic                          restart;
  logic                          mid_push, mid_full, mid_pop, mid_empty;
  mid_ctl_t                      front_ctl, mid_ctl;
  logic signed [SAMPLE_BITS-1:0] mid_sample;
  logic [MID_W-1:0]              mid_wdata, mid_rdata;

  logic                          out_push, out_full;
  logic [COLUMN_W-1:0]           res_column;
  logic signed [SAMPLE_BITS-1:0] res_min, res_max;
  logic [SAMPLE_BITS-1:0]        res_peak;
  logic                          res_last;
  logic [OUT_W-1:0]              out_wdata, out_rdata;

  mmpd_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_ctl_o  (front_ctl),
    .restart_o  (restart)
  );

  assign mid_wdata = {front_ctl, sample_i};

  mmpd_fifo #(
    .WIDTH(MID_W),
    .DEPTH(FIFO_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_ctl    = mid_rdata[MID_W-1:SAMPLE_BITS];
  assign mid_sample = mid_rdata[SAMPLE_BITS-1:0];

  mmpd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .mid_empty_i  (mid_empty),
    .mid_ctl_i    (mid_ctl),
    .mid_sample_i (mid_sample),
    .mid_pop_o    (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .column_o     (res_column),
    .min_value_o  (res_min),
    .max_value_o  (res_max),
    .peak_abs_o   (res_peak),
    .last_o       (res_last)
  );

  assign out_wdata = {res_column, res_min, res_max, res_peak, res_last};

  mmpd_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign column_o    = out_rdata[OUT_W-1 -: COLUMN_W];
  assign min_value_o = out_rdata[3*SAMPLE_BITS -: SAMPLE_BITS];
  assign max_value_o = out_rdata[2*SAMPLE_BITS -: SAMPLE_BITS];
  assign peak_abs_o  = out_rdata[SAMPLE_BITS -: SAMPLE_BITS];
  assign last_o      = out_rdata[0];

endmodule
